// File: rtl/core/cpr_pkg.sv
// Shared types, fixed-point constants and elaboration-time table functions
// for the complex phase rotator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpr_pkg;

  // Field and datapath widths
  localparam int unsigned FieldW   = 32;
  localparam int unsigned Guard    = 16;
  localparam int unsigned XW       = FieldW + Guard + 3;  // CORDIC x/y, covers gain growth
  localparam int unsigned MagW     = XW - 1;              // magnitude of x/y
  localparam int unsigned ProdFrac = 104;                 // Q24.40 times Q0.64 fraction bits
  localparam int unsigned GainFrac = 32;

  // 1/(2*pi) in Q0.64 and inverse CORDIC gain in Q0.32
  localparam logic [63:0] InvTwoPi   = 64'h28BE_60DB_9391_054A;
  localparam logic [31:0] GainQ32    = 32'h9B74_EDA8;
  localparam logic [31:0] GammaReset = 32'h0100_0000;

  // Control that travels with each item
  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

  typedef logic signed [XW-1:0] xy_t;

  // Restoring division, used only to build constants at elaboration
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // atan(2^-idx) in turns, rounded to units of 2^-dw turn
  function automatic logic [63:0] atan_turns(input int unsigned idx, input int unsigned dw);
    logic [63:0]  acc;
    logic [63:0]  term;
    logic [63:0]  t;
    logic [127:0] prod;
    int unsigned  odd;
    acc = '0;
    t   = 64'd1 << 61;
    if (idx != 0) begin
      // Taylor series in Q0.64 radians
      for (int k = 0; k < 32; k++) begin
        odd = 2 * k + 1;
        if (idx * odd <= 63) begin
          term = div_u64(64'd1 << (64 - idx * odd), 64'(odd));
          if (k[0]) begin
            acc = acc - term;
          end else begin
            acc = acc + term;
          end
        end
      end
      prod = {64'd0, acc} * {64'd0, InvTwoPi};
      t    = prod[127:64];
    end
    return (t + (64'd1 << (63 - dw))) >> (64 - dw);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/complex_phase_rotator_top.sv
// Complex phase rotator: amplitude times exp(-i*gamma*d) via CORDIC.
// Uses cpr_pkg, cpr_phase, cpr_stage and cpr_gain.
//
//   channel  direction  handshake              payload
//   input    in         in_valid_i/in_stall_o  diag_value_i state_re_i state_im_i is_last_i
//   output   out        out_valid_o/out_stall_i rot_re_o rot_im_o last_out_o
//   config   in         gamma_we_i             gamma_wdata_i
//
// One item per cycle while the output is not stalled; the pipe has four angle
// stages, one register per micro-rotation and two gain stages.
// Reset clears all valid bits and loads gamma with 1.0.
// A stalled output freezes the whole pipe; one more transfer is held in an
// input skid register, so in_stall_o is a register output.
`timescale 1ns / 1ps
`default_nettype none

module complex_phase_rotator_top #(
  parameter int unsigned CORDIC_STAGES = 32,
  parameter int unsigned DATA_WIDTH    = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               gamma_we_i,
  input  wire logic signed [31:0] gamma_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] diag_value_i,
  input  wire logic signed [31:0] state_re_i,
  input  wire logic signed [31:0] state_im_i,
  input  wire logic               is_last_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      rot_re_o,
  output logic signed [31:0]      rot_im_o,
  output logic                    last_out_o
);

  logic [31:0]        gamma_q;
  logic               skid_full_q, skid_full_d;
  logic               skid_last_q;
  logic signed [31:0] skid_diag_q, skid_re_q, skid_im_q;
  logic               en;

  cpr_pkg::ctl_t      ent_ctl, out_ctl;
  logic signed [31:0] ent_diag, ent_re, ent_im;

  cpr_pkg::ctl_t               c_ctl [CORDIC_STAGES+1];
  cpr_pkg::xy_t                c_x   [CORDIC_STAGES+1];
  cpr_pkg::xy_t                c_y   [CORDIC_STAGES+1];
  logic signed [DATA_WIDTH:0]  c_z   [CORDIC_STAGES+1];

  // Gain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= cpr_pkg::GammaReset;
    end else if (gamma_we_i) begin
      gamma_q <= gamma_wdata_i;
    end
  end

  // Pipe advances unless a finished result is held
  assign en = !(out_valid_o && out_stall_i);

  // Input skid
  always_comb begin
    skid_full_d = skid_full_q;
    if (en) begin
      skid_full_d = 1'b0;
    end else if (in_valid_i && !skid_full_q) begin
      skid_full_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_full_q <= 1'b0;
    end else begin
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_full_q) begin
      skid_diag_q <= diag_value_i;
      skid_re_q   <= state_re_i;
      skid_im_q   <= state_im_i;
      skid_last_q <= is_last_i;
    end
  end

  assign in_stall_o = skid_full_q;

  // Pipe entry picks the held transfer first
  always_comb begin
    if (skid_full_q) begin
      ent_ctl.valid = 1'b1;
      ent_ctl.last  = skid_last_q;
      ent_diag      = skid_diag_q;
      ent_re        = skid_re_q;
      ent_im        = skid_im_q;
    end else begin
      ent_ctl.valid = in_valid_i;
      ent_ctl.last  = is_last_i;
      ent_diag      = diag_value_i;
      ent_re        = state_re_i;
      ent_im        = state_im_i;
    end
  end

  cpr_phase #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_phase (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .gamma_i(gamma_q),
    .ctl_i  (ent_ctl),
    .diag_i (ent_diag),
    .re_i   (ent_re),
    .im_i   (ent_im),
    .ctl_o  (c_ctl[0]),
    .x_o    (c_x[0]),
    .y_o    (c_y[0]),
    .z_o    (c_z[0])
  );

  // Micro-rotation chain
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    cpr_stage #(
      .IDX       (i),
      .DATA_WIDTH(DATA_WIDTH)
    ) u_stage (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .ctl_i (c_ctl[i]),
      .x_i   (c_x[i]),
      .y_i   (c_y[i]),
      .z_i   (c_z[i]),
      .ctl_o (c_ctl[i+1]),
      .x_o   (c_x[i+1]),
      .y_o   (c_y[i+1]),
      .z_o   (c_z[i+1])
    );
  end

  cpr_gain u_gain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .ctl_i (c_ctl[CORDIC_STAGES]),
    .x_i   (c_x[CORDIC_STAGES]),
    .y_i   (c_y[CORDIC_STAGES]),
    .ctl_o (out_ctl),
    .re_o  (rot_re_o),
    .im_o  (rot_im_o)
  );

  assign out_valid_o = out_ctl.valid;
  assign last_out_o  = out_ctl.last;

endmodule

`default_nettype wire

// File: rtl/core/cpr_phase.sv
// Angle front end: gamma*d, scaling to turns, phase wrap and quadrant
// pre-rotation. Four register stages. Depends on cpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpr_phase #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic        [31:0]           gamma_i,
  input  wire cpr_pkg::ctl_t                ctl_i,
  input  wire logic signed [31:0]           diag_i,
  input  wire logic signed [31:0]           re_i,
  input  wire logic signed [31:0]           im_i,
  output cpr_pkg::ctl_t                     ctl_o,
  output cpr_pkg::xy_t                      x_o,
  output cpr_pkg::xy_t                      y_o,
  output logic signed [DATA_WIDTH:0]        z_o
);

  localparam int unsigned ZW  = DATA_WIDTH + 1;
  localparam int unsigned SW  = cpr_pkg::ProdFrac;
  localparam int unsigned HW  = 32;
  localparam int unsigned FW  = cpr_pkg::FieldW;
  localparam int unsigned GW  = cpr_pkg::Guard;
  localparam int unsigned XW  = cpr_pkg::XW;
  localparam logic [31:0] CLo = cpr_pkg::InvTwoPi[31:0];
  localparam logic [31:0] CHi = cpr_pkg::InvTwoPi[63:32];
  localparam logic signed [ZW-1:0] Qtr = {2'b00, 1'b1, {(DATA_WIDTH-2){1'b0}}};

  cpr_pkg::ctl_t ctl1_q, ctl2_q, ctl3_q, ctl4_q;

  logic signed [63:0]         prod_q;
  logic signed [31:0]         re1_q, im1_q, re2_q, im2_q, re3_q, im3_q;
  logic        [63:0]         pp00_q, pp01_q;
  logic signed [64:0]         pp10_q, pp11_q;
  logic        [DATA_WIDTH-1:0] pw_q;
  cpr_pkg::xy_t               x4_q, y4_q;
  logic signed [ZW-1:0]       z4_q;

  logic [SW-1:0]              e00, e01, e10, e11, sum;
  logic [DATA_WIDTH-1:0]      ang;
  logic signed [ZW-1:0]       zext, z_d;
  cpr_pkg::xy_t               xe, ye, x_d, y_d;

  // Control pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
    end
  end

  // Partial-product sum, kept mod 2^104; phase word is the top bits
  always_comb begin
    e00 = SW'(pp00_q);
    e01 = SW'(pp01_q) << HW;
    e10 = SW'(pp10_q) << HW;
    e11 = SW'(pp11_q) << (2 * HW);
    sum = e00 + e01 + e10 + e11;
  end

  // Negate to get the rotation angle, then fold into +-1/4 turn
  always_comb begin
    ang  = ~pw_q + 1'b1;
    zext = {ang[DATA_WIDTH-1], ang};
    xe   = {{(XW-FW-GW){re3_q[FW-1]}}, re3_q, {GW{1'b0}}};
    ye   = {{(XW-FW-GW){im3_q[FW-1]}}, im3_q, {GW{1'b0}}};
    x_d  = xe;
    y_d  = ye;
    z_d  = zext;
    if (zext > Qtr) begin
      x_d = -ye;
      y_d = xe;
      z_d = zext - Qtr;
    end else if (zext < -Qtr) begin
      x_d = ye;
      y_d = -xe;
      z_d = zext + Qtr;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: gain times diagonal value
      prod_q <= $signed(gamma_i) * diag_i;
      re1_q  <= re_i;
      im1_q  <= im_i;
      // stage 2: split product by 1/(2*pi)
      pp00_q <= prod_q[31:0] * CLo;
      pp01_q <= prod_q[31:0] * CHi;
      pp10_q <= $signed(prod_q[63:32]) * $signed({1'b0, CLo});
      pp11_q <= $signed(prod_q[63:32]) * $signed({1'b0, CHi});
      re2_q  <= re1_q;
      im2_q  <= im1_q;
      // stage 3: phase word
      pw_q   <= sum[SW-1 -: DATA_WIDTH];
      re3_q  <= re2_q;
      im3_q  <= im2_q;
      // stage 4: quadrant pre-rotation
      x4_q   <= x_d;
      y4_q   <= y_d;
      z4_q   <= z_d;
    end
  end

  assign ctl_o = ctl4_q;
  assign x_o   = x4_q;
  assign y_o   = y4_q;
  assign z_o   = z4_q;

endmodule

`default_nettype wire

// File: rtl/core/cpr_stage.sv
// One CORDIC micro-rotation with its output register.
// Depends on cpr_pkg for the datapath type and the arctangent constant.
`timescale 1ns / 1ps
`default_nettype none

module cpr_stage #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire cpr_pkg::ctl_t         ctl_i,
  input  wire cpr_pkg::xy_t          x_i,
  input  wire cpr_pkg::xy_t          y_i,
  input  wire logic signed [DATA_WIDTH:0] z_i,
  output cpr_pkg::ctl_t              ctl_o,
  output cpr_pkg::xy_t               x_o,
  output cpr_pkg::xy_t               y_o,
  output logic signed [DATA_WIDTH:0] z_o
);

  localparam int unsigned ZW = DATA_WIDTH + 1;
  localparam logic signed [ZW-1:0] Angle = ZW'(cpr_pkg::atan_turns(IDX, DATA_WIDTH));

  cpr_pkg::ctl_t        ctl_q;
  cpr_pkg::xy_t         x_q, y_q, xs, ys;
  logic signed [ZW-1:0] z_q;

  assign xs = x_i >>> IDX;
  assign ys = y_i >>> IDX;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  // Rotate toward zero residual angle
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!z_i[ZW-1]) begin
        x_q <= x_i - ys;
        y_q <= y_i + xs;
        z_q <= z_i - Angle;
      end else begin
        x_q <= x_i + ys;
        y_q <= y_i - xs;
        z_q <= z_i + Angle;
      end
    end
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;

endmodule

`default_nettype wire

// File: rtl/core/cpr_gain.sv
// CORDIC gain removal with rounding and Q2.30 saturation, two stages.
// Depends on cpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpr_gain (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire cpr_pkg::ctl_t  ctl_i,
  input  wire cpr_pkg::xy_t   x_i,
  input  wire cpr_pkg::xy_t   y_i,
  output cpr_pkg::ctl_t       ctl_o,
  output logic signed [31:0]  re_o,
  output logic signed [31:0]  im_o
);

  localparam int unsigned MW    = cpr_pkg::MagW;
  localparam int unsigned Split = MW / 2;
  localparam int unsigned HiW   = MW - Split;
  localparam int unsigned GnW   = cpr_pkg::GainFrac;
  localparam int unsigned W     = MW + GnW;
  localparam int unsigned RS    = GnW + cpr_pkg::Guard;
  localparam int unsigned RW    = W - RS;
  localparam logic [W-1:0]  RoundC = W'(1) << (RS - 1);
  localparam logic [RW-1:0] SatLim = RW'(64'h8000_0000);

  cpr_pkg::ctl_t ctl1_q, ctl2_q;

  cpr_pkg::xy_t             v      [2];
  logic [MW-1:0]            mag    [2];
  logic [Split+GnW-1:0]     lo_d   [2];
  logic [HiW+GnW-1:0]       hi_d   [2];
  logic [Split+GnW-1:0]     lo_q   [2];
  logic [HiW+GnW-1:0]       hi_q   [2];
  logic                     neg_q  [2];
  logic [W-1:0]             full   [2];
  logic [RW-1:0]            rnd    [2];
  logic [31:0]              rsat   [2];
  logic [31:0]              res_d  [2];
  logic [31:0]              res_q  [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  // Magnitude times gain, cut into two partial products
  always_comb begin
    v[0] = x_i;
    v[1] = y_i;
    for (int c = 0; c < 2; c++) begin
      mag[c]  = v[c][MW] ? MW'(-v[c]) : MW'(v[c]);
      lo_d[c] = mag[c][Split-1:0] * cpr_pkg::GainQ32;
      hi_d[c] = mag[c][MW-1:Split] * cpr_pkg::GainQ32;
    end
  end

  // Round half away from zero, clamp, restore sign
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      full[c] = (W'(hi_q[c]) << Split) + W'(lo_q[c]) + RoundC;
      rnd[c]  = full[c][W-1:RS];
      rsat[c] = (rnd[c] > SatLim) ? 32'h8000_0000 : rnd[c][31:0];
      if (neg_q[c]) begin
        res_d[c] = ~rsat[c] + 1'b1;
      end else if (rsat[c] == 32'h8000_0000) begin
        res_d[c] = 32'h7FFF_FFFF;
      end else begin
        res_d[c] = rsat[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 2; c++) begin
        lo_q[c]  <= lo_d[c];
        hi_q[c]  <= hi_d[c];
        neg_q[c] <= v[c][MW];
        res_q[c] <= res_d[c];
      end
    end
  end

  assign ctl_o = ctl2_q;
  assign re_o  = $signed(res_q[0]);
  assign im_o  = $signed(res_q[1]);

endmodule

`default_nettype wire

// File: sim/complex_phase_rotator_top_test.sv
// Self-checking testbench for complex_phase_rotator_top: random and corner-case amplitudes
// are rotated by exp(-i*gamma*d) under several gain settings, then checked against a
// bit-exact CORDIC predictor. Needs only the RTL of the rotator.
`timescale 1ns / 1ps

// Arithmetic constants of the rotator datapath
localparam int          RotStages   = 32;
localparam int          RotWidth    = 32;
localparam int          GuardBits   = 16;
localparam logic [63:0] TurnPerRad  = 64'h28BE_60DB_9391_054A;  // 1/(2*pi), Q0.64
localparam logic [31:0] InvGainQ32  = 32'h9B74_EDA8;            // 1/K, Q0.32
localparam longint      QuarterTurn = 64'sd1073741824;          // 2^30, quarter turn
localparam logic [31:0] UnityGain   = 32'h0100_0000;            // 1.0 in Q8.24

typedef struct packed {
  logic signed [31:0] re;
  logic signed [31:0] im;
  logic               last;
} rotated_amp_t;

// Holds the predicted amplitudes in transfer order and compares each result
class rotation_checker;
  longint             arc_steps [RotStages];
  logic signed [31:0] gain;
  rotated_amp_t       due_rotations [$];
  int unsigned        mismatches;
  int unsigned        checked;
  int unsigned        lasts;

  function new();
    logic [63:0]  acc;
    logic [63:0]  term;
    logic [63:0]  t;
    logic [127:0] prod;
    gain       = UnityGain;
    mismatches = 0;
    checked    = 0;
    lasts      = 0;
    // atan(2^-i) in turns, Taylor series in Q0.64 radians
    for (int i = 0; i < RotStages; i++) begin
      if (i == 0) begin
        t = 64'd1 << 61;
      end else begin
        acc = '0;
        for (int k = 0; i * (2 * k + 1) <= 63; k++) begin
          term = (64'd1 << (64 - i * (2 * k + 1))) / 64'(2 * k + 1);
          if (k % 2 == 1) begin
            acc = acc - term;
          end else begin
            acc = acc + term;
          end
        end
        prod = 128'(acc) * 128'(TurnPerRad);
        t    = prod[127:64];
      end
      arc_steps[i] = longint'((t + (64'd1 << (63 - RotWidth))) >> (64 - RotWidth));
    end
  endfunction

  // Remove the CORDIC gain, round half away from zero, clip to Q2.30
  function logic [31:0] scale_and_clip(longint v);
    logic [63:0]  mag;
    logic [127:0] prod;
    logic [63:0]  r;
    longint       s;
    mag  = (v < 0) ? -v : v;
    prod = 128'(mag) * 128'(InvGainQ32);
    prod = prod + (128'd1 << 47);
    r    = prod[111:48];
    if (r > 64'h8000_0000) r = 64'h8000_0000;
    s = (v < 0) ? -$signed(r) : $signed(r);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    return s[31:0];
  endfunction

  // Amplitude times exp(-i*gain*d)
  function rotated_amp_t rotate_by_gain(logic signed [31:0] diag, logic signed [31:0] re,
                                        logic signed [31:0] im, logic last);
    logic signed [127:0] wide_p;
    logic signed [127:0] wide_k;
    logic signed [127:0] turns;
    logic [31:0]         phase;
    logic signed [31:0]  angle;
    longint              x, y, z, xs, ys, t;
    rotated_amp_t        r;
    wide_p = longint'(gain) * longint'(diag);
    wide_k = {64'd0, TurnPerRad};
    turns  = wide_p * wide_k;
    phase  = turns[103:72];
    angle  = -phase;
    z      = angle;
    x      = longint'(re) * (64'sd1 << GuardBits);
    y      = longint'(im) * (64'sd1 << GuardBits);
    // quadrant pre-rotation
    if (z > QuarterTurn) begin
      t = x; x = -y; y = t; z -= QuarterTurn;
    end else if (z < -QuarterTurn) begin
      t = x; x = y; y = -t; z += QuarterTurn;
    end
    for (int i = 0; i < RotStages; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= arc_steps[i];
      end else begin
        x += ys; y -= xs; z += arc_steps[i];
      end
    end
    r.re   = scale_and_clip(x);
    r.im   = scale_and_clip(y);
    r.last = last;
    return r;
  endfunction

  function void note_input(logic signed [31:0] diag, logic signed [31:0] re,
                           logic signed [31:0] im, logic last);
    due_rotations.push_back(rotate_by_gain(diag, re, im, last));
    if (last) lasts++;
  endfunction

  function void check_result(logic signed [31:0] re, logic signed [31:0] im, logic last);
    rotated_amp_t want;
    if (due_rotations.size() == 0) begin
      $error("result with no rotation pending: rot_re %0d rot_im %0d", re, im);
      mismatches++;
      return;
    end
    want = due_rotations.pop_front();
    if (re !== want.re) begin
      $error("result %0d rot_re: expected %0d, got %0d", checked, want.re, re);
      mismatches++;
    end
    if (im !== want.im) begin
      $error("result %0d rot_im: expected %0d, got %0d", checked, want.im, im);
      mismatches++;
    end
    if (last !== want.last) begin
      $error("result %0d last_out: expected %0b, got %0b", checked, want.last, last);
      mismatches++;
    end
    checked++;
  endfunction
endclass

module complex_phase_rotator_top_test;

  localparam int PipeDepth     = RotStages + 6 + 10;  // pipe plus skid, with margin
  localparam int WatchdogLimit = 2000;
  localparam int Phases        = 9;
  localparam int ItemsPerPhase = 150;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_BLOCKS
  } stall_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               gamma_we_i;
  logic signed [31:0] gamma_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [31:0] diag_value_i;
  logic signed [31:0] state_re_i;
  logic signed [31:0] state_im_i;
  logic               is_last_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] rot_re_o;
  logic signed [31:0] rot_im_o;
  logic               last_out_o;

  rotation_checker rotations;
  int unsigned     idle_cycles = 0;
  int unsigned     stall_left  = 0;
  stall_mode_e     stall_mode  = STALL_NONE;
  int unsigned     gains_used  = 1;

  complex_phase_rotator_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .gamma_we_i   (gamma_we_i),
    .gamma_wdata_i(gamma_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .diag_value_i (diag_value_i),
    .state_re_i   (state_re_i),
    .state_im_i   (state_im_i),
    .is_last_i    (is_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .rot_re_o     (rot_re_o),
    .rot_im_o     (rot_im_o),
    .last_out_o   (last_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Offer one amplitude and hold it until the transfer
  task automatic push_amplitude(input logic [31:0] diag, input logic [31:0] re,
                                input logic [31:0] im, input logic last);
    in_valid_i   <= 1'b1;
    diag_value_i <= diag;
    state_re_i   <= re;
    state_im_i   <= im;
    is_last_i    <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    rotations.note_input(diag, re, im, last);
  endtask

  // Wait until every predicted rotation has come out and the pipe is quiet
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (rotations.due_rotations.size() != 0) @(posedge clk_i);
    repeat (PipeDepth) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic [31:0] g);
    gamma_we_i    <= 1'b1;
    gamma_wdata_i <= g;
    @(posedge clk_i);
    gamma_we_i <= 1'b0;
    rotations.gain = g;
    gains_used++;
  endtask

  // Random operand: mostly full range, with corners, small values and
  // near multiples of pi/4 for the diagonal value
  function automatic logic [31:0] random_word(input bit angle);
    int k;
    k = int'($urandom_range(0, 16)) - 8;
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 5))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          4: return 32'hFFFF_FFFF;
          default: return 32'h4000_0000;
        endcase
      end
      2, 3: begin
        if (angle) return 32'(k * 51472 + int'($urandom_range(0, 6)) - 3);
        return 32'(int'($urandom_range(0, 2000)) - 1000);
      end
      4: return 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      default: return $urandom();
    endcase
  endfunction

  // Result checking and receiver stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      rotations.check_result(rot_re_o, rot_im_o, last_out_o);
    end
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 150);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= stall_left[2];
    endcase
  end

  // Watchdog: stop when neither side moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WatchdogLimit) begin
      $error("no transfer for %0d cycles", WatchdogLimit);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned burst_left;
    int unsigned gap;
    int unsigned gap_max;
    rotations     = new();
    burst_left    = 0;
    rst_ni        <= 1'b0;
    gamma_we_i    <= 1'b0;
    gamma_wdata_i <= '0;
    in_valid_i    <= 1'b0;
    diag_value_i  <= '0;
    state_re_i    <= '0;
    state_im_i    <= '0;
    is_last_i     <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners under the reset gain of 1.0
    push_amplitude(32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    push_amplitude(32'd0, 32'h8000_0000, 32'h8000_0000, 1'b1);
    push_amplitude(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    push_amplitude(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    push_amplitude(32'd0, 32'd0, 32'd0, 1'b1);
    // pi/4 on a full-scale amplitude saturates
    push_amplitude(32'sd51472, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    push_amplitude(32'sd51472, 32'h8000_0000, 32'h8000_0000, 1'b0);
    push_amplitude(-32'sd51472, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    // quadrant boundaries and half turns
    push_amplitude(32'sd102944, 32'h4000_0000, 32'd0, 1'b0);
    push_amplitude(-32'sd102944, 32'h4000_0000, 32'h4000_0000, 1'b0);
    push_amplitude(32'sd154416, 32'h8000_0000, 32'd0, 1'b0);
    push_amplitude(32'sd205887, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    push_amplitude(-32'sd205887, 32'd1, 32'hFFFF_FFFF, 1'b0);
    push_amplitude(32'sd411775, 32'h1234_5678, 32'hEDCB_A988, 1'b0);
    // extreme diagonal values, many whole turns
    push_amplitude(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    push_amplitude(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    push_amplitude(32'd1, 32'h4000_0000, 32'hC000_0000, 1'b0);
    push_amplitude(32'hFFFF_FFFF, 32'hC000_0000, 32'h4000_0000, 1'b0);

    // Random part, one gain setting per phase, extremes included
    for (int phase = 0; phase < Phases; phase++) begin
      if (phase > 0) begin
        drain_pipe();
        case (phase)
          1: write_gain(32'h7FFF_FFFF);
          2: write_gain(32'h8000_0000);
          3: write_gain(32'h0000_0000);
          4: write_gain(32'hFF00_0000);
          5: write_gain(UnityGain);
          7: write_gain(32'(int'($urandom_range(0, 1 << 27)) - (1 << 26)));
          default: write_gain($urandom());
        endcase
      end
      gap_max = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 4 : 16);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap        = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
          if (gap != 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
        burst_left--;
        push_amplitude(random_word(1'b1), random_word(1'b0), random_word(1'b0),
                       $urandom_range(0, 7) == 0);
      end
    end

    drain_pipe();
    $display("Checked %0d rotated amplitudes (%0d flagged last) over %0d gain settings",
             rotations.checked, rotations.lasts, gains_used);
    if (rotations.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/cpr_pkg.sv
rtl/core/cpr_phase.sv
rtl/core/cpr_stage.sv
rtl/core/cpr_gain.sv
rtl/core/complex_phase_rotator_top.sv
sim/complex_phase_rotator_top_test.sv
